// File: rtl/afk_pkg.sv
package afk_pkg;

    localparam int ANGLE_W    = 16;
    localparam int LEN_W      = 16;
    localparam int TOOL_W     = 17;
    localparam int OUT_W      = 18;
    localparam int CORDIC_W   = 20;
    localparam int STEP_W     = 4;
    localparam int PROD_W     = 36;
    localparam int SUM_W      = 37;
    localparam int RND_W      = 21;
    localparam int POSSUM_W   = 22;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;
    localparam int LINK_W     = 3;
    localparam int ROW_W      = 2;
    localparam int PHASE_W    = 3;
    localparam int ANGLES     = 6;

    localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [CORDIC_W-1:0] PI_Q        = 20'sd205887;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q   = 20'sd102944;

    localparam logic signed [OUT_W-1:0] ONE_Q   = 18'sd65536;
    localparam logic signed [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] POS_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHOULDER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOREARM  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOOL     = 8'd3;

    localparam logic [LEN_W-1:0]  SHOULDER_RST = 16'd2753;
    localparam logic [LEN_W-1:0]  UPPER_RST    = 16'd8520;
    localparam logic [LEN_W-1:0]  FOREARM_RST  = 16'd7537;
    localparam logic [TOOL_W-1:0] TOOL_RST     = 17'd0;

    // link update phases (one product issued per phase)
    localparam logic [PHASE_W-1:0] PH_R0C   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_US    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_R0S   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_UC    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_POS   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_WRITE = 3'd5;
    // tool phases
    localparam logic [PHASE_W-1:0] PH_TMUL  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TADD  = 3'd1;

    typedef struct packed {
        logic                 load;
        logic                 cordic_init;
        logic                 cordic_step;
        logic                 row_op;
        logic                 tool_op;
        logic                 out_load;
        logic [LINK_W-1:0]    link;
        logic [ROW_W-1:0]     row;
        logic [PHASE_W-1:0]   phase;
        logic [STEP_W-1:0]    step;
    } afk_cmd_t;

    function automatic logic signed [CORDIC_W-1:0] atan_q(input logic [STEP_W-1:0] i);
        logic signed [CORDIC_W-1:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/afk_ifs.sv
interface afk_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] angle_one;
    logic [15:0] angle_two;
    logic [15:0] angle_three;
    logic [15:0] angle_four;
    logic [15:0] angle_five;
    logic [15:0] angle_six;
    logic [2:0]  joints_used;
    logic        add_tool;

    modport source (output valid, angle_one, angle_two, angle_three, angle_four,
                     angle_five, angle_six, joints_used, add_tool, input ready);
    modport sink (input valid, angle_one, angle_two, angle_three, angle_four,
                   angle_five, angle_six, joints_used, add_tool, output ready);
endinterface

interface afk_out_if;
    logic        valid;
    logic        ready;
    logic [17:0] rot_xx;
    logic [17:0] rot_xy;
    logic [17:0] rot_xz;
    logic [17:0] rot_yx;
    logic [17:0] rot_yy;
    logic [17:0] rot_yz;
    logic [17:0] rot_zx;
    logic [17:0] rot_zy;
    logic [17:0] rot_zz;
    logic [17:0] pos_x;
    logic [17:0] pos_y;
    logic [17:0] pos_z;

    modport source (output valid, rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz,
                     rot_zx, rot_zy, rot_zz, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz,
                   rot_zx, rot_zy, rot_zz, pos_x, pos_y, pos_z, output ready);
endinterface

interface afk_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [16:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/afk_datapath.sv
module afk_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  afk_pkg::afk_cmd_t                      cmd,
    input  logic [afk_pkg::ANGLES-1:0][afk_pkg::ANGLE_W-1:0] angles,
    input  logic                                   cfg_we,
    input  logic [afk_pkg::CFG_IDX_W-1:0]          cfg_idx,
    input  logic [afk_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic [8:0][afk_pkg::OUT_W-1:0]         rot_out,
    output logic [2:0][afk_pkg::OUT_W-1:0]         pos_out
);

    localparam logic signed [afk_pkg::CORDIC_W-1:0] ONE_W = 20'sd65536;

    logic [afk_pkg::ANGLE_W-1:0] angle_reg [afk_pkg::ANGLES];
    logic [afk_pkg::LEN_W-1:0]   shoulder_reg, upper_reg, forearm_reg;
    logic [afk_pkg::TOOL_W-1:0]  tool_reg;

    logic signed [afk_pkg::CORDIC_W-1:0] cx_reg, cy_reg, cz_reg;
    logic                                flip_reg;

    logic signed [afk_pkg::OUT_W-1:0]  rot_reg [3][3];
    logic signed [afk_pkg::OUT_W-1:0]  pos_reg [3];
    logic signed [afk_pkg::PROD_W-1:0] prod_reg, acc_reg;
    logic signed [afk_pkg::OUT_W-1:0]  t0_reg, t1_reg;
    logic [8:0][afk_pkg::OUT_W-1:0]    out_rot_reg;
    logic [2:0][afk_pkg::OUT_W-1:0]    out_pos_reg;

    logic signed [afk_pkg::CORDIC_W-1:0] z_init, z_wrap, xs, ys, at, xf, yf;
    logic signed [afk_pkg::OUT_W-1:0]    cosv, sinv, rot0, rot1, rot2, u, w, xpos, ypos;
    logic signed [afk_pkg::OUT_W-1:0]    mul_a, mul_b, tool_ext;
    logic signed [afk_pkg::PROD_W-1:0]   prod_next;
    logic signed [afk_pkg::OUT_W-1:0]    pos_new, rot_sum_a, rot_sum_b;
    logic                                flip_init;

    function automatic logic signed [afk_pkg::OUT_W-1:0] clamp_cs(
        input logic signed [afk_pkg::CORDIC_W-1:0] v);
        logic signed [afk_pkg::OUT_W-1:0] r;
        if (v > ONE_W)
            r = afk_pkg::ONE_Q;
        else if (v < -ONE_W)
            r = -afk_pkg::ONE_Q;
        else
            r = v[afk_pkg::OUT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [afk_pkg::RND_W-1:0] rnd(
        input logic signed [afk_pkg::SUM_W-1:0] v);
        logic signed [afk_pkg::SUM_W-1:0] t;
        t = v + 37'sd32768;
        return t[afk_pkg::SUM_W-1:16];
    endfunction

    function automatic logic signed [afk_pkg::OUT_W-1:0] clamp_rot(
        input logic signed [afk_pkg::RND_W-1:0] v);
        logic signed [afk_pkg::OUT_W-1:0] r;
        if (v > 21'sd65536)
            r = afk_pkg::ONE_Q;
        else if (v < -21'sd65536)
            r = -afk_pkg::ONE_Q;
        else
            r = v[afk_pkg::OUT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [afk_pkg::OUT_W-1:0] sat_pos(
        input logic signed [afk_pkg::OUT_W-1:0] p,
        input logic signed [afk_pkg::PROD_W-1:0] q);
        logic signed [afk_pkg::POSSUM_W-1:0] s;
        logic signed [afk_pkg::OUT_W-1:0]    r;
        s = afk_pkg::POSSUM_W'(p) + afk_pkg::POSSUM_W'(rnd(afk_pkg::SUM_W'(q)));
        if (s > afk_pkg::POSSUM_W'(afk_pkg::POS_MAX))
            r = afk_pkg::POS_MAX;
        else if (s < afk_pkg::POSSUM_W'(afk_pkg::POS_MIN))
            r = afk_pkg::POS_MIN;
        else
            r = s[afk_pkg::OUT_W-1:0];
        return r;
    endfunction

    // cordic input range reduction and one rotation step
    always_comb
    begin
        z_init    = afk_pkg::CORDIC_W'($signed({angle_reg[cmd.link], 3'b000}));
        flip_init = 1'b0;
        z_wrap    = z_init;
        if (z_init > afk_pkg::HALF_PI_Q)
        begin
            z_wrap    = z_init - afk_pkg::PI_Q;
            flip_init = 1'b1;
        end
        else if (z_init < -afk_pkg::HALF_PI_Q)
        begin
            z_wrap    = z_init + afk_pkg::PI_Q;
            flip_init = 1'b1;
        end
        xs   = cx_reg >>> cmd.step;
        ys   = cy_reg >>> cmd.step;
        at   = afk_pkg::atan_q(cmd.step);
        xf   = flip_reg ? -cx_reg : cx_reg;
        yf   = flip_reg ? -cy_reg : cy_reg;
        cosv = clamp_cs(xf);
        sinv = clamp_cs(yf);
    end

    // operand selection from the fixed link twists
    always_comb
    begin
        rot0 = rot_reg[cmd.row][0];
        rot1 = rot_reg[cmd.row][1];
        rot2 = rot_reg[cmd.row][2];
        case (cmd.link)
            3'd0:    begin u = rot1;  w = rot2;  end
            3'd1:    begin u = -rot2; w = rot1;  end
            3'd2:    begin u = rot1;  w = rot2;  end
            3'd3:    begin u = -rot2; w = rot1;  end
            3'd4:    begin u = rot2;  w = -rot1; end
            default: begin u = -rot2; w = rot1;  end
        endcase
        case (cmd.link)
            3'd1:    begin xpos = w;    ypos = afk_pkg::OUT_W'(shoulder_reg); end
            3'd2:    begin xpos = rot0; ypos = afk_pkg::OUT_W'(upper_reg);    end
            3'd3:    begin xpos = w;    ypos = afk_pkg::OUT_W'(forearm_reg);  end
            default: begin xpos = w;    ypos = '0;                            end
        endcase
        tool_ext = afk_pkg::OUT_W'($signed(tool_reg));
        if (cmd.tool_op)
        begin
            mul_a = rot2;
            mul_b = tool_ext;
        end
        else
        begin
            case (cmd.phase)
                afk_pkg::PH_R0C: begin mul_a = rot0; mul_b = cosv; end
                afk_pkg::PH_US:  begin mul_a = u;    mul_b = sinv; end
                afk_pkg::PH_R0S: begin mul_a = rot0; mul_b = sinv; end
                afk_pkg::PH_UC:  begin mul_a = u;    mul_b = cosv; end
                default:         begin mul_a = xpos; mul_b = ypos; end
            endcase
        end
        prod_next = mul_a * mul_b;
        rot_sum_a = clamp_rot(rnd(afk_pkg::SUM_W'(acc_reg) + afk_pkg::SUM_W'(prod_reg)));
        rot_sum_b = clamp_rot(rnd(afk_pkg::SUM_W'(prod_reg) - afk_pkg::SUM_W'(acc_reg)));
        pos_new   = sat_pos(pos_reg[cmd.row], prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shoulder_reg <= afk_pkg::SHOULDER_RST;
            upper_reg    <= afk_pkg::UPPER_RST;
            forearm_reg  <= afk_pkg::FOREARM_RST;
            tool_reg     <= afk_pkg::TOOL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                afk_pkg::REG_SHOULDER: shoulder_reg <= cfg_data[afk_pkg::LEN_W-1:0];
                afk_pkg::REG_UPPER:    upper_reg    <= cfg_data[afk_pkg::LEN_W-1:0];
                afk_pkg::REG_FOREARM:  forearm_reg  <= cfg_data[afk_pkg::LEN_W-1:0];
                afk_pkg::REG_TOOL:     tool_reg     <= cfg_data[afk_pkg::TOOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < afk_pkg::ANGLES; i++)
                angle_reg[i] <= angles[i];
            for (int r = 0; r < 3; r++)
            begin
                pos_reg[r] <= '0;
                for (int c = 0; c < 3; c++)
                    rot_reg[r][c] <= (r == c) ? afk_pkg::ONE_Q : '0;
            end
        end
        if (cmd.cordic_init)
        begin
            cx_reg   <= afk_pkg::CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= z_wrap;
            flip_reg <= flip_init;
        end
        else if (cmd.cordic_step)
        begin
            if (cz_reg >= 0)
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
        end
        if (cmd.row_op || cmd.tool_op)
            prod_reg <= prod_next;
        if (cmd.row_op)
        begin
            case (cmd.phase)
                afk_pkg::PH_US:  acc_reg <= prod_reg;
                afk_pkg::PH_R0S: t0_reg  <= rot_sum_a;
                afk_pkg::PH_UC:  acc_reg <= prod_reg;
                afk_pkg::PH_POS: t1_reg  <= rot_sum_b;
                afk_pkg::PH_WRITE:
                begin
                    pos_reg[cmd.row]    <= pos_new;
                    rot_reg[cmd.row][0] <= t0_reg;
                    rot_reg[cmd.row][1] <= t1_reg;
                    rot_reg[cmd.row][2] <= w;
                end
                default: ;
            endcase
        end
        if (cmd.tool_op && cmd.phase == afk_pkg::PH_TADD)
            pos_reg[cmd.row] <= pos_new;
        if (cmd.out_load)
        begin
            for (int r = 0; r < 3; r++)
            begin
                out_pos_reg[r] <= pos_reg[r];
                for (int c = 0; c < 3; c++)
                    out_rot_reg[r*3 + c] <= rot_reg[r][c];
            end
        end
    end

    assign rot_out = out_rot_reg;
    assign pos_out = out_pos_reg;

endmodule

// File: rtl/afk_ctrl.sv
module afk_ctrl #(
    parameter int JOINT_COUNT = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [2:0]                 joints_used,
    input  logic                       add_tool,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output afk_pkg::afk_cmd_t          cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CINIT  = 3'd1;
    localparam logic [2:0] S_CORDIC = 3'd2;
    localparam logic [2:0] S_ROW    = 3'd3;
    localparam logic [2:0] S_TOOL   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    localparam logic [afk_pkg::LINK_W-1:0] MAX_LINKS = afk_pkg::LINK_W'(JOINT_COUNT);
    localparam logic [afk_pkg::ROW_W-1:0]  LAST_ROW  = 2'd2;

    logic [2:0]                   state_reg, state_next;
    logic [afk_pkg::LINK_W-1:0]   link_reg, link_next, n_reg, n_next, n_in;
    logic                         tool_reg, tool_next;
    logic [afk_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [afk_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [afk_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         accept, out_load;

    always_comb
    begin
        n_in       = (joints_used > MAX_LINKS) ? MAX_LINKS : joints_used;
        in_ready   = (state_reg == S_IDLE);
        accept     = in_valid && in_ready;
        out_load   = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
        state_next = state_reg;
        link_next  = link_reg;
        n_next     = n_reg;
        tool_next  = tool_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next     = n_in;
                    tool_next  = add_tool;
                    link_next  = '0;
                    row_next   = '0;
                    phase_next = '0;
                    if (n_in != '0)
                        state_next = S_CINIT;
                    else if (add_tool)
                        state_next = S_TOOL;
                    else
                        state_next = S_OUT;
                end
            end
            S_CINIT:
            begin
                step_next  = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == afk_pkg::LAST_STEP)
                begin
                    row_next   = '0;
                    phase_next = '0;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == afk_pkg::PH_WRITE)
                begin
                    phase_next = '0;
                    row_next   = row_reg + 1'b1;
                    if (row_reg == LAST_ROW)
                    begin
                        row_next  = '0;
                        link_next = link_reg + 1'b1;
                        if (link_reg + 1'b1 == n_reg)
                            state_next = tool_reg ? S_TOOL : S_OUT;
                        else
                            state_next = S_CINIT;
                    end
                end
            end
            S_TOOL:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == afk_pkg::PH_TADD)
                begin
                    phase_next = '0;
                    row_next   = row_reg + 1'b1;
                    if (row_reg == LAST_ROW)
                        state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            link_reg      <= '0;
            n_reg         <= '0;
            tool_reg      <= 1'b0;
            step_reg      <= '0;
            row_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            link_reg      <= link_next;
            n_reg         <= n_next;
            tool_reg      <= tool_next;
            step_reg      <= step_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd.load        = accept;
        cmd.cordic_init = (state_reg == S_CINIT);
        cmd.cordic_step = (state_reg == S_CORDIC);
        cmd.row_op      = (state_reg == S_ROW);
        cmd.tool_op     = (state_reg == S_TOOL);
        cmd.out_load    = out_load;
        cmd.link        = link_reg;
        cmd.row         = row_reg;
        cmd.phase       = phase_reg;
        cmd.step        = step_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/arm_forward_kinematics_unit.sv
// Forward kinematics of a six-joint modified-DH arm, fixed point.
// Channels: in_ch (sink) takes six Q2.13 joint angles, joints_used and add_tool;
// out_ch (source) returns the 3x3 rotation (Q16) and the saturated position
// (Q16 metres); cfg (sink) writes the link registers by index and is always ready.
// Each input transfer is processed alone. Per chained link the block runs a
// sine/cosine setup step, 16 CORDIC iterations and the row updates on a single
// 18x18 multiplier (six phases per rotation row, three rows); with add_tool set,
// three tool rows of two phases each follow the last link. The next input is
// taken only once the result is in the output register, so a new item is never
// started before the last is done. The shared multiplier and the CORDIC loop force this.
// in_ch.ready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next item is accepted while it waits.
// If the receiver stalls, the result holds and a second finished item waits in
// the datapath until out_ch takes the first one.
// Reset clears the sequencer and the output valid, and loads the register
// defaults (shoulder 2753, upper arm 8520, forearm 7537, tool 0).
module arm_forward_kinematics_unit #(
    parameter int JOINT_COUNT = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    afk_in_if.sink     in_ch,
    afk_out_if.source  out_ch,
    afk_cfg_if.sink    cfg
);

    afk_pkg::afk_cmd_t                                   cmd;
    logic [afk_pkg::ANGLES-1:0][afk_pkg::ANGLE_W-1:0]    angles;
    logic [8:0][afk_pkg::OUT_W-1:0]                      rot_out;
    logic [2:0][afk_pkg::OUT_W-1:0]                      pos_out;
    logic                                                in_ready;
    logic                                                out_valid;

    // Config is taken every cycle; the user must send writes only while idle, the block does not enforce it.
    assign cfg.ready = 1'b1;

    // pack the joint angles, joint one at index zero
    assign angles[0] = in_ch.angle_one;
    assign angles[1] = in_ch.angle_two;
    assign angles[2] = in_ch.angle_three;
    assign angles[3] = in_ch.angle_four;
    assign angles[4] = in_ch.angle_five;
    assign angles[5] = in_ch.angle_six;

    afk_ctrl #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .joints_used (in_ch.joints_used),
        .add_tool    (in_ch.add_tool),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ch.ready),
        .cmd         (cmd)
    );

    afk_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .angles   (angles),
        .cfg_we   (cfg.valid),
        .cfg_idx  (cfg.index),
        .cfg_data (cfg.data),
        .rot_out  (rot_out),
        .pos_out  (pos_out)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;

    // row-major rotation, then position
    assign out_ch.rot_xx = rot_out[0];
    assign out_ch.rot_xy = rot_out[1];
    assign out_ch.rot_xz = rot_out[2];
    assign out_ch.rot_yx = rot_out[3];
    assign out_ch.rot_yy = rot_out[4];
    assign out_ch.rot_yz = rot_out[5];
    assign out_ch.rot_zx = rot_out[6];
    assign out_ch.rot_zy = rot_out[7];
    assign out_ch.rot_zz = rot_out[8];
    assign out_ch.pos_x  = pos_out[0];
    assign out_ch.pos_y  = pos_out[1];
    assign out_ch.pos_z  = pos_out[2];

`ifndef SYNTHESIS
    // the sequencer is busy in the cycle after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input accepted twice in a row");

    // row phase never runs past the write-back phase
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_op |-> (cmd.phase <= afk_pkg::PH_WRITE))
        else $error("row phase out of range");

    // the presented rot_xx diagonal entry stays within the unit range
    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ($signed(out_ch.rot_xx) <= $signed(afk_pkg::ONE_Q) &&
                          $signed(out_ch.rot_xx) >= -$signed(afk_pkg::ONE_Q)))
        else $error("rotation entry out of range");
`endif

endmodule
